>>> src/selective_repeat_receive_window_defines.svh
// ----------------------------------------------------------------------------
// Selective repeat receive window: assertion macros
// Shared concurrent check forms, sampled on the rising clock edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/srw_pkg.sv
// ----------------------------------------------------------------------------
// srw_pkg
// Types, codes and constants shared by the receive window modules.
// ----------------------------------------------------------------------------
`default_nettype none

package srw_pkg;

  localparam int unsigned RingSize      = 16;
  localparam int unsigned PacketBytes   = 1024;
  localparam int unsigned CmdQueueDepth = 2;
  localparam int unsigned CfgIndexWidth = 4;

  localparam logic [CfgIndexWidth-1:0] CfgTotalLength = CfgIndexWidth'(0);
  localparam logic [CfgIndexWidth-1:0] CfgWindowSpan  = CfgIndexWidth'(1);

  localparam logic [4:0] SpanReset = 5'd8;

  // Largest payload length a slot may hold.
  localparam logic [9:0] LenMax = (PacketBytes - 1 > 1023) ? 10'd1023
                                                             : 10'(PacketBytes - 1);

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_DELIVER = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_IGNORED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CMD_ACK,
    CMD_ERR,
    CMD_IGN
  } cmd_op_e;

  typedef struct packed {
    logic [7:0] seq_number;
    logic [9:0] payload_len;
  } srw_in_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  slot;
    logic [31:0] offset;
    logic [9:0]  length;
    logic        finished;
    logic        last;
  } srw_out_t;

  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] seq;
    logic [9:0] len;
  } srw_cmd_t;

  typedef struct packed {
    logic       idle;
    logic       done;
    logic       halted;
    logic [7:0] window_start;
  } srw_status_t;

endpackage

`default_nettype wire

>>> src/srw_front.sv
// ----------------------------------------------------------------------------
// srw_front
// Holds one header word and classifies it against the window state once
// the back end has settled: ignore, error, drop or acknowledge.
// ----------------------------------------------------------------------------
`default_nettype none

module srw_front #(
  parameter int unsigned RING_SIZE = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  input  srw_pkg::srw_in_t      in_word_i,
  output logic                  in_stall_o,
  input  wire  [4:0]            window_span_i,
  input  srw_pkg::srw_status_t  status_i,
  output logic                  push_o,
  output srw_pkg::srw_cmd_t     cmd_o
);
  import srw_pkg::*;

  localparam int unsigned IW = $clog2(RING_SIZE);
  localparam logic [8:0]  RingLim = 9'(RING_SIZE);

  logic          hold_valid_q, hold_valid_d;
  srw_in_t       hold_q;
  logic          classify;
  logic          accept;
  logic [IW-1:0] seq_idx;
  logic [IW-1:0] ws_idx;
  logic [IW:0]   diff;
  logic [IW:0]   win_pos;
  logic          in_window;
  logic          bad_seq;
  logic [9:0]    len_sat;

  assign classify   = hold_valid_q && status_i.idle;
  assign in_stall_o = hold_valid_q && !classify;
  assign accept     = in_valid_i && !in_stall_o;

  assign seq_idx = hold_q.seq_number[IW-1:0];
  assign ws_idx  = status_i.window_start[IW-1:0];
  assign bad_seq = {1'b0, hold_q.seq_number} >= RingLim;

  // Distance from window start, modulo the ring.
  assign diff      = {1'b0, seq_idx} - {1'b0, ws_idx};
  assign win_pos   = diff[IW] ? diff + (IW+1)'(RING_SIZE) : diff;
  assign in_window = 9'(win_pos) < 9'(window_span_i);

  assign len_sat = (hold_q.payload_len > LenMax) ? LenMax : hold_q.payload_len;

  always_comb begin
    push_o    = 1'b0;
    cmd_o.op  = CMD_ACK;
    cmd_o.seq = hold_q.seq_number;
    cmd_o.len = len_sat;
    if (classify) begin
      if (status_i.done || status_i.halted) begin
        push_o   = 1'b1;
        cmd_o.op = CMD_IGN;
      end else if (bad_seq) begin
        push_o   = 1'b1;
        cmd_o.op = CMD_ERR;
      end else if (in_window) begin
        push_o   = 1'b1;
        cmd_o.op = CMD_ACK;
      end
    end
  end

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (classify) hold_valid_d = 1'b0;
    if (accept)   hold_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) hold_q <= in_word_i;
  end

endmodule

`default_nettype wire

>>> src/srw_cmd_fifo.sv
// ----------------------------------------------------------------------------
// srw_cmd_fifo
// Short command queue between the classifier and the executing back end.
// ----------------------------------------------------------------------------
`default_nettype none

module srw_cmd_fifo (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  srw_pkg::srw_cmd_t  data_i,
  input  wire                pop_i,
  output srw_pkg::srw_cmd_t  data_o,
  output logic               valid_o
);
  import srw_pkg::*;

  localparam int unsigned PW = (CmdQueueDepth > 1) ? $clog2(CmdQueueDepth) : 1;
  localparam int unsigned CW = $clog2(CmdQueueDepth + 1);

  srw_cmd_t        mem_q [CmdQueueDepth];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            do_push, do_pop;

  assign valid_o = count_q != '0;
  assign do_pop  = pop_i && valid_o;
  assign do_push = push_i && (count_q != CW'(CmdQueueDepth));
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    return (p == PW'(CmdQueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

>>> src/srw_back.sv
// ----------------------------------------------------------------------------
// srw_back
// Executes queued commands: marks slots, emits acknowledge, error and
// ignored words, then drains in-order slots as delivery words.
// ----------------------------------------------------------------------------
`default_nettype none

module srw_back #(
  parameter int unsigned RING_SIZE = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cmd_valid_i,
  input  srw_pkg::srw_cmd_t     cmd_i,
  output logic                  pop_o,
  input  wire  [31:0]           total_length_i,
  input  wire                   rearm_i,
  output logic                  out_valid_o,
  output srw_pkg::srw_out_t     out_word_o,
  input  wire                   out_stall_i,
  output srw_pkg::srw_status_t  status_o
);
  import srw_pkg::*;

  localparam int unsigned IW = $clog2(RING_SIZE);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_EMIT
  } state_e;

  state_e                 state_q, state_d;
  logic [RING_SIZE-1:0]   map_q, map_d;
  logic [IW-1:0]          ws_q, ws_d, ws_next;
  logic [31:0]            delivered_q, delivered_d;
  logic                   done_q, done_d;
  logic                   halted_q, halted_d;
  logic                   out_valid_q, out_valid_d;
  srw_out_t               out_q, out_d;
  srw_cmd_t               cmd_q, cmd_d;
  logic [31:0]            room_q, room_d;
  logic [9:0]             len_rd_q;
  logic [9:0]             len_mem_q [RING_SIZE];
  logic                   mem_we;
  logic                   out_free;
  logic [IW-1:0]          seq_idx;
  logic                   more;
  logic                   hit;
  logic [9:0]             len_out;

  assign out_free = !out_valid_q || !out_stall_i;
  assign seq_idx  = cmd_q.seq[IW-1:0];
  assign ws_next  = (ws_q == IW'(RING_SIZE - 1)) ? '0 : ws_q + 1'b1;
  assign hit      = {22'd0, len_rd_q} >= room_q;
  assign len_out  = hit ? room_q[9:0] : len_rd_q;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign status_o.idle         = (state_q == ST_IDLE) && !cmd_valid_i;
  assign status_o.done         = done_q;
  assign status_o.halted       = halted_q;
  assign status_o.window_start = 8'(ws_q);

  always_comb begin
    state_d     = state_q;
    map_d       = map_q;
    ws_d        = ws_q;
    delivered_d = delivered_q;
    done_d      = done_q;
    halted_d    = halted_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    cmd_d       = cmd_q;
    room_d      = room_q;
    mem_we      = 1'b0;
    pop_o       = 1'b0;
    more        = map_q[ws_q] || (seq_idx == ws_q);

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_d.slot     = '0;
          out_d.offset   = '0;
          out_d.length   = '0;
          out_d.finished = done_q;
          out_d.last     = 1'b1;
          unique case (cmd_q.op)
            CMD_ERR: begin
              out_d.kind = KIND_ERROR;
              halted_d   = 1'b1;
              state_d    = ST_IDLE;
            end
            CMD_IGN: begin
              out_d.kind = KIND_IGNORED;
              state_d    = ST_IDLE;
            end
            CMD_ACK: begin
              mem_we           = 1'b1;
              map_d[seq_idx]   = 1'b1;
              out_d.kind       = KIND_ACK;
              out_d.slot       = cmd_q.seq[3:0];
              out_d.last       = !more;
              state_d          = more ? ST_READ : ST_IDLE;
            end
            default: begin
              out_valid_d = out_valid_q && out_stall_i;
              out_d       = out_q;
              state_d     = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        room_d  = total_length_i - delivered_q;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_d.kind     = KIND_DELIVER;
          out_d.slot     = 4'(ws_q);
          out_d.offset   = delivered_q;
          out_d.length   = len_out;
          out_d.finished = hit;
          delivered_d    = delivered_q + 32'(len_out);
          if (hit) begin
            // Total reached: the window stops on this slot.
            done_d     = 1'b1;
            out_d.last = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            map_d[ws_q] = 1'b0;
            ws_d        = ws_next;
            out_d.last  = !map_q[ws_next];
            state_d     = map_q[ws_next] ? ST_READ : ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (rearm_i) begin
      map_d       = '0;
      ws_d        = '0;
      delivered_d = '0;
      done_d      = 1'b0;
      halted_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      map_q       <= '0;
      ws_q        <= '0;
      delivered_q <= '0;
      done_q      <= 1'b0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      map_q       <= map_d;
      ws_q        <= ws_d;
      delivered_q <= delivered_d;
      done_q      <= done_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    cmd_q  <= cmd_d;
    room_q <= room_d;
  end

  // Slot length store: written on acknowledge, read at the window start.
  always_ff @(posedge clk_i) begin
    if (mem_we) len_mem_q[seq_idx] <= cmd_q.len;
    if (state_q == ST_READ) len_rd_q <= len_mem_q[ws_q];
  end

endmodule

`default_nettype wire

>>> src/selective_repeat_receive_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Receive side of a selective repeat transfer: acknowledges headers inside
// the window and delivers in-order slots with their destination offsets.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Word
//  in        input      valid / stall      srw_in_t  (seq_number, payload_len)
//  out       output     valid / stall      srw_out_t (kind, slot, offset, ...)
//  cfg       input      valid / ready      index + 32-bit data, ready always high
//
//  Steps: accept, classify once the back end is idle, queue, execute into the
//  output register. After a dropped header the next one is classified without
//  waiting on the back end; after any other it waits for the back end, which
//  reads the slot length and emits a word for each delivered slot.
//  Reset clears the window state; no clearing pass is needed.
//  An output stall holds the output register and the back end behind it.
//
`default_nettype none

`include "selective_repeat_receive_window_defines.svh"

module selective_repeat_receive_window #(
  parameter int unsigned RING_SIZE = srw_pkg::RingSize
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  input  srw_pkg::srw_in_t                     in_word_i,
  output logic                                 in_stall_o,
  output logic                                 out_valid_o,
  output srw_pkg::srw_out_t                    out_word_o,
  input  wire                                  out_stall_i,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [srw_pkg::CfgIndexWidth-1:0]    cfg_index_i,
  input  wire  [31:0]                          cfg_data_i
);
  import srw_pkg::*;

  logic [31:0]  total_length_q;
  logic [4:0]   window_span_q;
  logic         cfg_write;
  logic         rearm;
  srw_status_t  status;
  logic         cmd_push;
  srw_cmd_t     cmd_in;
  srw_cmd_t     cmd_head;
  logic         cmd_valid;
  logic         cmd_pop;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  // Writing the total length rearms the transfer.
  assign rearm       = cfg_write && (cfg_index_i == CfgTotalLength);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_length_q <= '0;
      window_span_q  <= SpanReset;
    end else if (cfg_write) begin
      if (cfg_index_i == CfgTotalLength) total_length_q <= cfg_data_i;
      if (cfg_index_i == CfgWindowSpan)  window_span_q  <= cfg_data_i[4:0];
    end
  end

  // Front: hold and classify one header word.
  srw_front #(
    .RING_SIZE (RING_SIZE)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_word_i     (in_word_i),
    .in_stall_o    (in_stall_o),
    .window_span_i (window_span_q),
    .status_i      (status),
    .push_o        (cmd_push),
    .cmd_o         (cmd_in)
  );

  // Queue: decouple classification from execution.
  srw_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .valid_o (cmd_valid)
  );

  // Back: execute commands, drain the window, drive the output register.
  srw_back #(
    .RING_SIZE (RING_SIZE)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd_head),
    .pop_o          (cmd_pop),
    .total_length_i (total_length_q),
    .rearm_i        (rearm),
    .out_valid_o    (out_valid_o),
    .out_word_o     (out_word_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status)
  );

  // Classify only against settled window state.
  `SRW_ASSERT_SAME(a_push_when_idle, clk_i, rst_ni, cmd_push, status.idle, "push while busy")

  // A halted block never shows a delivery.
  `SRW_ASSERT_SAME(a_no_deliver_halted, clk_i, rst_ni, out_valid_o && (out_word_o.kind == KIND_DELIVER), !status.halted, "delivery while halted")

  // A finished word always closes its header's burst.
  `SRW_ASSERT_SAME(a_finished_is_last, clk_i, rst_ni, out_valid_o && out_word_o.finished, out_word_o.last, "finished word not last")

  // Rearm clears the transfer state.
  `SRW_ASSERT_NEXT(a_rearm_clears, clk_i, rst_ni, rearm, !status.done && !status.halted && (status.window_start == 8'd0), "rearm did not clear")

endmodule

`default_nettype wire
